// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

    // Heap geometry
    localparam int HEAP_CAPACITY = 64;
    localparam int IDX_W         = $clog2(HEAP_CAPACITY);
    localparam int CNT_W         = $clog2(HEAP_CAPACITY + 1);
    localparam int CHILD_W       = IDX_W + 2;

    // Field widths
    localparam int TIME_W        = 32;
    localparam int PAY_W         = 16;
    localparam int COUNT_OUT_W   = 7;

    // Operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0] key;
        logic [PAY_W-1:0]  pay;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP
    } t_state;

    // One finished item, handed from the sequencer to the result register
    typedef struct packed {
        logic                   done;
        t_status                status;
        logic [TIME_W-1:0]      out_time;
        logic [PAY_W-1:0]       out_payload;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_result;

endpackage

// ===== rtl/bmhq_ram.sv =====
module bmhq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered reads on two ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/bmhq_seq.sv =====
module bmhq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [bmhq_pkg::TIME_W-1:0] i_key_time,
    input  logic [bmhq_pkg::PAY_W-1:0]  i_event_payload,
    output logic                        o_we,
    output logic [bmhq_pkg::IDX_W-1:0]  o_waddr,
    output bmhq_pkg::t_entry            o_wdata,
    output logic [bmhq_pkg::IDX_W-1:0]  o_raddr_a,
    output logic [bmhq_pkg::IDX_W-1:0]  o_raddr_b,
    input  bmhq_pkg::t_entry            i_rdata_a,
    input  bmhq_pkg::t_entry            i_rdata_b,
    output bmhq_pkg::t_result           o_result
);

    bmhq_pkg::t_state                  r_state, n_state;
    logic [bmhq_pkg::CNT_W-1:0]        r_count, n_count;
    logic [bmhq_pkg::IDX_W-1:0]        r_pos, n_pos;
    bmhq_pkg::t_entry                  r_ent, n_ent;
    bmhq_pkg::t_entry                  r_out, n_out;

    logic [bmhq_pkg::IDX_W-1:0]        parent;
    logic [bmhq_pkg::CHILD_W-1:0]      lc, rc, cnt_ext;
    logic                              lc_ok, rc_ok, take_l, take_r;
    logic [bmhq_pkg::TIME_W-1:0]       cand_key;

    // Tree neighbors of the current hole
    assign parent   = bmhq_pkg::IDX_W'((r_pos - 1'b1) >> 1);
    assign lc       = {1'b0, r_pos, 1'b1};
    assign rc       = bmhq_pkg::CHILD_W'(lc + 1'b1);
    assign cnt_ext  = bmhq_pkg::CHILD_W'(r_count);
    assign lc_ok    = lc < cnt_ext;
    assign rc_ok    = rc < cnt_ext;

    // Child pick: strictly smaller wins, left first
    assign take_l   = lc_ok && (i_rdata_a.key < r_ent.key);
    assign cand_key = take_l ? i_rdata_a.key : r_ent.key;
    assign take_r   = rc_ok && (i_rdata_b.key < cand_key);

    assign busy = (r_state != bmhq_pkg::S_IDLE);

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_ent <= n_ent;
        r_out <= n_out;
    end

    // Sequencer: hole-based sift up and sift down
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_ent     = r_ent;
        n_out     = r_out;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = r_ent;
        o_raddr_a = r_pos;
        o_raddr_b = r_pos;
        o_result  = '0;

        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (start) begin
                    if (i_operation == bmhq_pkg::OP_INSERT) begin
                        if (r_count == bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_CAPACITY)) begin
                            o_result.done        = 1'b1;
                            o_result.status      = bmhq_pkg::ST_FULL;
                            o_result.entry_count = bmhq_pkg::COUNT_OUT_W'(r_count);
                        end else begin
                            n_ent   = '{key: i_key_time, pay: i_event_payload};
                            n_out   = '0;
                            n_pos   = bmhq_pkg::IDX_W'(r_count);
                            n_count = bmhq_pkg::CNT_W'(r_count + 1'b1);
                            n_state = bmhq_pkg::S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            o_result.done        = 1'b1;
                            o_result.status      = bmhq_pkg::ST_EMPTY;
                            o_result.entry_count = bmhq_pkg::COUNT_OUT_W'(r_count);
                        end else begin
                            // Fetch root and last entry
                            o_raddr_a = '0;
                            o_raddr_b = bmhq_pkg::IDX_W'(r_count - 1'b1);
                            n_count   = bmhq_pkg::CNT_W'(r_count - 1'b1);
                            n_state   = bmhq_pkg::S_DN_LOAD;
                        end
                    end
                end
            end

            bmhq_pkg::S_UP_RD: begin
                if (r_pos == '0) begin
                    o_we                 = 1'b1;
                    n_state              = bmhq_pkg::S_IDLE;
                    o_result.done        = 1'b1;
                    o_result.status      = bmhq_pkg::ST_OK;
                    o_result.entry_count = bmhq_pkg::COUNT_OUT_W'(r_count);
                end else begin
                    o_raddr_a = parent;
                    n_state   = bmhq_pkg::S_UP_CMP;
                end
            end

            bmhq_pkg::S_UP_CMP: begin
                o_we = 1'b1;
                if (i_rdata_a.key > r_ent.key) begin
                    // Pull the parent down into the hole
                    o_wdata = i_rdata_a;
                    n_pos   = parent;
                    n_state = bmhq_pkg::S_UP_RD;
                end else begin
                    n_state              = bmhq_pkg::S_IDLE;
                    o_result.done        = 1'b1;
                    o_result.status      = bmhq_pkg::ST_OK;
                    o_result.entry_count = bmhq_pkg::COUNT_OUT_W'(r_count);
                end
            end

            bmhq_pkg::S_DN_LOAD: begin
                n_out   = i_rdata_a;
                n_ent   = i_rdata_b;
                n_pos   = '0;
                n_state = bmhq_pkg::S_DN_RD;
            end

            bmhq_pkg::S_DN_RD: begin
                o_raddr_a = bmhq_pkg::IDX_W'(lc);
                o_raddr_b = bmhq_pkg::IDX_W'(rc);
                n_state   = bmhq_pkg::S_DN_CMP;
            end

            bmhq_pkg::S_DN_CMP: begin
                o_we = 1'b1;
                if (take_r) begin
                    o_wdata = i_rdata_b;
                    n_pos   = bmhq_pkg::IDX_W'(rc);
                    n_state = bmhq_pkg::S_DN_RD;
                end else if (take_l) begin
                    o_wdata = i_rdata_a;
                    n_pos   = bmhq_pkg::IDX_W'(lc);
                    n_state = bmhq_pkg::S_DN_RD;
                end else begin
                    n_state              = bmhq_pkg::S_IDLE;
                    o_result.done        = 1'b1;
                    o_result.status      = bmhq_pkg::ST_OK;
                    o_result.out_time    = r_out.key;
                    o_result.out_payload = r_out.pay;
                    o_result.entry_count = bmhq_pkg::COUNT_OUT_W'(r_count);
                end
            end

            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/binary_min_heap_queue_top.sv =====
// Min-heap event queue: start is taken when busy is low and launches one insert or
// extract-min beat; exactly one result follows, shown for a single cycle with o_done
// high, and the receiver cannot stall it, so it must capture on that cycle. A full or
// empty case answers in the cycle after start and never raises busy. An insert holds busy
// while it climbs, an extract while it loads the root and last entry and then descends;
// each level costs one read step and one compare-and-write step on the single heap
// memory, and the result is registered from the finishing step. busy drops in the same
// cycle that o_done is high, and a new start may be taken at the edge that ends it. Ties
// on time never move an entry; on a tie between children the left is taken.
module binary_min_heap_queue_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [bmhq_pkg::TIME_W-1:0]       i_key_time,
    input  logic [bmhq_pkg::PAY_W-1:0]        i_event_payload,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [bmhq_pkg::TIME_W-1:0]       o_out_time,
    output logic [bmhq_pkg::PAY_W-1:0]        o_out_payload,
    output logic [bmhq_pkg::COUNT_OUT_W-1:0]  o_entry_count
);

    logic                             we;
    logic [bmhq_pkg::IDX_W-1:0]       waddr, raddr_a, raddr_b;
    bmhq_pkg::t_entry                 wdata, rdata_a, rdata_b;
    bmhq_pkg::t_result                result;
    logic                             r_done;
    bmhq_pkg::t_result                r_result;

    bmhq_ram #(
        .DEPTH (bmhq_pkg::HEAP_CAPACITY),
        .AW    (bmhq_pkg::IDX_W),
        .DW    (bmhq_pkg::ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    bmhq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_key_time      (i_key_time),
        .i_event_payload (i_event_payload),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_raddr_a       (raddr_a),
        .o_raddr_b       (raddr_b),
        .i_rdata_a       (rdata_a),
        .i_rdata_b       (rdata_b),
        .o_result        (result)
    );

    // Strobe the result beat for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= result.done;
        end
    end

    // Hold the result fields from the finishing cycle
    always_ff @(posedge i_clk) begin
        if (result.done) begin
            r_result <= result;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_result.status;
    assign o_out_time    = r_result.out_time;
    assign o_out_payload = r_result.out_payload;
    assign o_entry_count = r_result.entry_count;

endmodule

// ===== sim/bmhq_checker.sv =====
module bmhq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic                                i_operation,
    input  logic [bmhq_pkg::TIME_W-1:0]         i_key_time,
    input  logic [bmhq_pkg::PAY_W-1:0]          i_event_payload,
    input  logic                                i_done,
    input  logic [1:0]                          i_status,
    input  logic [bmhq_pkg::TIME_W-1:0]         i_out_time,
    input  logic [bmhq_pkg::PAY_W-1:0]          i_out_payload,
    input  logic [bmhq_pkg::COUNT_OUT_W-1:0]    i_entry_count,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_full_seen,
    output int                                  o_empty_seen
);

    typedef struct packed {
        bmhq_pkg::t_status                status;
        logic [bmhq_pkg::TIME_W-1:0]      out_time;
        logic [bmhq_pkg::PAY_W-1:0]       out_payload;
        logic [bmhq_pkg::COUNT_OUT_W-1:0] entry_count;
    } t_outcome;

    // Shadow copy of the heap, kept in step with accepted beats
    logic [bmhq_pkg::TIME_W-1:0] shadow_key [bmhq_pkg::HEAP_CAPACITY];
    logic [bmhq_pkg::PAY_W-1:0]  shadow_pay [bmhq_pkg::HEAP_CAPACITY];
    int unsigned                 shadow_fill;

    t_outcome expected_outcomes [$];

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic [bmhq_pkg::TIME_W-1:0] k;
        logic [bmhq_pkg::PAY_W-1:0]  p;
        k = shadow_key[a];
        p = shadow_pay[a];
        shadow_key[a] = shadow_key[b];
        shadow_pay[a] = shadow_pay[b];
        shadow_key[b] = k;
        shadow_pay[b] = p;
    endfunction

    // Apply one beat to the shadow heap and return what the block should report
    function automatic t_outcome heap_apply(input logic op,
                                            input logic [bmhq_pkg::TIME_W-1:0] key,
                                            input logic [bmhq_pkg::PAY_W-1:0] pay);
        t_outcome    res;
        int unsigned pos;
        int unsigned parent;
        int unsigned lc;
        int unsigned rc;
        int unsigned best;
        res = '{status: bmhq_pkg::ST_OK, out_time: '0, out_payload: '0, entry_count: '0};
        if (op == bmhq_pkg::OP_INSERT) begin
            if (shadow_fill >= bmhq_pkg::HEAP_CAPACITY) begin
                res.status = bmhq_pkg::ST_FULL;
            end else begin
                pos = shadow_fill;
                shadow_key[pos] = key;
                shadow_pay[pos] = pay;
                shadow_fill++;
                // climb while the parent is strictly later
                while (pos != 0) begin
                    parent = (pos - 1) / 2;
                    if (!(shadow_key[parent] > shadow_key[pos]))
                        break;
                    swap_slots(pos, parent);
                    pos = parent;
                end
            end
        end else begin
            if (shadow_fill == 0) begin
                res.status = bmhq_pkg::ST_EMPTY;
            end else begin
                res.out_time    = shadow_key[0];
                res.out_payload = shadow_pay[0];
                shadow_fill--;
                shadow_key[0] = shadow_key[shadow_fill];
                shadow_pay[0] = shadow_pay[shadow_fill];
                // sink toward the strictly earlier child, left wins a tie
                pos = 0;
                forever begin
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    best = pos;
                    if (lc < shadow_fill && shadow_key[lc] < shadow_key[best])
                        best = lc;
                    if (rc < shadow_fill && shadow_key[rc] < shadow_key[best])
                        best = rc;
                    if (best == pos)
                        break;
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        res.entry_count = shadow_fill[bmhq_pkg::COUNT_OUT_W-1:0];
        return res;
    endfunction

    // Compare each result beat with the oldest outstanding one, then log new input beats
    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            expected_outcomes.delete();
        end else begin
            if (i_done) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_out_time !== want.out_time) begin
                        $error("out_time: expected %0h, got %0h", want.out_time, i_out_time);
                        o_fail_count++;
                    end
                    if (i_out_payload !== want.out_payload) begin
                        $error("out_payload: expected %0h, got %0h",
                               want.out_payload, i_out_payload);
                        o_fail_count++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                want = heap_apply(i_operation, i_key_time, i_event_payload);
                if (want.status == bmhq_pkg::ST_FULL)
                    o_full_seen++;
                if (want.status == bmhq_pkg::ST_EMPTY)
                    o_empty_seen++;
                expected_outcomes.push_back(want);
            end
        end
        o_pending = expected_outcomes.size();
    end

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_BEATS    = 430;

    logic                                 i_clk           = 1'b0;
    logic                                 i_rst_n         = 1'b0;
    logic                                 start           = 1'b0;
    logic                                 i_operation     = bmhq_pkg::OP_INSERT;
    logic [bmhq_pkg::TIME_W-1:0]          i_key_time      = '0;
    logic [bmhq_pkg::PAY_W-1:0]           i_event_payload = '0;
    logic                                 busy;
    logic                                 o_done;
    logic [1:0]                           o_status;
    logic [bmhq_pkg::TIME_W-1:0]          o_out_time;
    logic [bmhq_pkg::PAY_W-1:0]           o_out_payload;
    logic [bmhq_pkg::COUNT_OUT_W-1:0]     o_entry_count;

    int          fail_count;
    int          pending;
    int          full_seen;
    int          empty_seen;
    int unsigned idle_pct    = 0;
    int unsigned beats_sent  = 0;
    int unsigned stall_count = 0;

    binary_min_heap_queue_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_key_time     (i_key_time),
        .i_event_payload(i_event_payload),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_out_time     (o_out_time),
        .o_out_payload  (o_out_payload),
        .o_entry_count  (o_entry_count)
    );

    bmhq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_operation    (i_operation),
        .i_key_time     (i_key_time),
        .i_event_payload(i_event_payload),
        .i_done         (o_done),
        .i_status       (o_status),
        .i_out_time     (o_out_time),
        .i_out_payload  (o_out_payload),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Half the keys are tiny or extreme so ties are common; the rest are full-range random
    function automatic logic [bmhq_pkg::TIME_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // Hold start until the block takes the beat; idle first at the current rate
    task automatic send_beat(input logic op, input logic [bmhq_pkg::TIME_W-1:0] key,
                             input logic [bmhq_pkg::PAY_W-1:0] pay);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_key_time      <= key;
        i_event_payload <= pay;
        do @(posedge i_clk); while (busy);
        beats_sent++;
    endtask

    // Random traffic in bursts: fill past capacity, drain past empty, or mixed
    task automatic run_phase(input int unsigned pct, input int unsigned n);
        int unsigned goal;
        int unsigned len;
        int unsigned ins_pct;
        idle_pct = pct;
        goal     = beats_sent + n;
        while (beats_sent < goal) begin
            case ($urandom_range(9))
                0, 1: begin
                    len     = bmhq_pkg::HEAP_CAPACITY + 6;
                    ins_pct = 100;
                end
                2, 3: begin
                    len     = bmhq_pkg::HEAP_CAPACITY + 6;
                    ins_pct = 0;
                end
                default: begin
                    len     = $urandom_range(40, 8);
                    ins_pct = $urandom_range(75, 25);
                end
            endcase
            repeat (len) begin
                if ($urandom_range(99) < ins_pct)
                    send_beat(bmhq_pkg::OP_INSERT, pick_key(),
                              bmhq_pkg::PAY_W'($urandom_range(16'hFFFF)));
                else
                    send_beat(bmhq_pkg::OP_EXTRACT, $urandom,
                              bmhq_pkg::PAY_W'($urandom_range(16'hFFFF)));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty extract, extreme fields, equal keys, tie between children
        idle_pct = 15;
        send_beat(bmhq_pkg::OP_EXTRACT, '1, '1);
        send_beat(bmhq_pkg::OP_INSERT, 32'd5, 16'h1111);
        send_beat(bmhq_pkg::OP_INSERT, 32'd5, 16'h2222);
        send_beat(bmhq_pkg::OP_INSERT, '1, '1);
        send_beat(bmhq_pkg::OP_INSERT, '0, '0);
        send_beat(bmhq_pkg::OP_INSERT, 32'd5, 16'h3333);
        send_beat(bmhq_pkg::OP_INSERT, 32'd3, 16'hAAAA);
        send_beat(bmhq_pkg::OP_INSERT, 32'h8000_0000, 16'h8000);
        repeat (8) send_beat(bmhq_pkg::OP_EXTRACT, '0, '0);
        send_beat(bmhq_pkg::OP_INSERT, 32'd9, 16'h5555);
        send_beat(bmhq_pkg::OP_INSERT, 32'd9, 16'h6666);
        send_beat(bmhq_pkg::OP_INSERT, 32'd9, 16'h7777);
        repeat (4) send_beat(bmhq_pkg::OP_EXTRACT, '0, '0);

        run_phase(15, PHASE_BEATS);
        run_phase(88, PHASE_BEATS);
        run_phase(0, PHASE_BEATS);
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d insert/extract beats over three idle profiles.", beats_sent);
        $display("Saw %0d inserts dropped on a full heap and %0d extracts on an empty one.",
                 full_seen, empty_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
